FILE: sv/ksm_pkg.sv
`default_nettype none

package ksm_pkg;

  // Field and state widths
  localparam int unsigned SAMP_W    = 16;
  localparam int unsigned COV_W     = 24;
  localparam int unsigned EST_W     = 32;
  localparam int unsigned K_W       = 16;
  localparam int unsigned AXES      = 3;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned CNT_W     = 4;

  // Configuration register indexes (byte address is 4 times the index)
  localparam logic [2:0] REG_ACC_Q  = 3'd0;
  localparam logic [2:0] REG_ACC_R  = 3'd1;
  localparam logic [2:0] REG_ACC_P0 = 3'd2;
  localparam logic [2:0] REG_GYR_Q  = 3'd3;
  localparam logic [2:0] REG_GYR_R  = 3'd4;
  localparam logic [2:0] REG_GYR_P0 = 3'd5;

  // Register reset values, unsigned Q8.16
  localparam logic [COV_W-1:0] RST_ACC_Q  = 24'd4096;
  localparam logic [COV_W-1:0] RST_ACC_R  = 24'd65536;
  localparam logic [COV_W-1:0] RST_ACC_P0 = 24'd14464;
  localparam logic [COV_W-1:0] RST_GYR_Q  = 24'd65536;
  localparam logic [COV_W-1:0] RST_GYR_R  = 24'd4096;
  localparam logic [COV_W-1:0] RST_GYR_P0 = 24'd14464;

  localparam logic [COV_W-1:0] COV_MAX = 24'hFF_FFFF;
  localparam logic [K_W-1:0]   K_MAX   = 16'hFFFF;

  // Control from the sequencer to the gain unit
  typedef struct packed {
    logic start;
    logic seed;
    logic bank;
  } ksm_gain_ctl_t;

  // Control from the sequencer to each axis lane
  typedef struct packed {
    logic seed;
    logic diff;
    logic mul;
    logic upd;
    logic bank;
  } ksm_lane_ctl_t;

endpackage

`default_nettype wire

FILE: sv/ksm_gain.sv
`default_nettype none

module ksm_gain (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ksm_pkg::ksm_gain_ctl_t     ctl_i,
  input  wire logic [ksm_pkg::COV_W-1:0]  q_i,
  input  wire logic [ksm_pkg::COV_W-1:0]  r_i,
  input  wire logic [ksm_pkg::COV_W-1:0]  init_i,
  output logic      [ksm_pkg::K_W-1:0]    k_o,
  output logic                            done_o
);

  localparam logic [1:0] G_IDLE = 2'd0;
  localparam logic [1:0] G_DIV  = 2'd1;
  localparam logic [1:0] G_COV  = 2'd2;

  logic [1:0]                  gst_q, gst_d;
  logic [ksm_pkg::CNT_W-1:0]   cnt_q;
  logic                        bank_q;
  logic [ksm_pkg::COV_W-1:0]   cov_q [2];
  logic [ksm_pkg::COV_W-1:0]   p1_q;
  logic [ksm_pkg::COV_W:0]     den_q;
  logic [ksm_pkg::COV_W:0]     rem_q;
  logic [ksm_pkg::K_W-1:0]     quo_q;

  logic [ksm_pkg::COV_W:0]     p_sum;
  logic [ksm_pkg::COV_W-1:0]   p1;
  logic [ksm_pkg::COV_W:0]     den;
  logic [ksm_pkg::COV_W+1:0]   rem_sh;
  logic [ksm_pkg::COV_W+1:0]   rem_sub;
  logic                        fits;
  logic [ksm_pkg::K_W:0]       one_minus_k;
  logic [ksm_pkg::COV_W+ksm_pkg::K_W:0] cov_prod;

  // Predict: p1 = sat(p + q), denominator p1 + r
  assign p_sum = {1'b0, cov_q[ctl_i.bank]} + {1'b0, q_i};
  assign p1    = p_sum[ksm_pkg::COV_W] ? ksm_pkg::COV_MAX : p_sum[ksm_pkg::COV_W-1:0];
  assign den   = {1'b0, p1} + {1'b0, r_i};

  // One restoring division bit per cycle
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = (rem_sh >= {1'b0, den_q});

  // Covariance update p = p1 * (1 - k)
  assign one_minus_k = {1'b1, {ksm_pkg::K_W{1'b0}}} - {1'b0, quo_q};
  assign cov_prod    = p1_q * one_minus_k;

  assign k_o    = quo_q;
  assign done_o = (gst_q == G_COV);

  always_comb begin
    gst_d = gst_q;
    case (gst_q)
      G_IDLE: begin
        if (ctl_i.start && !ctl_i.seed) begin
          gst_d = (r_i == '0) ? G_COV : G_DIV;
        end
      end
      G_DIV: begin
        if (cnt_q == ksm_pkg::CNT_W'(ksm_pkg::DIV_STEPS - 1)) begin
          gst_d = G_COV;
        end
      end
      G_COV:   gst_d = G_IDLE;
      default: gst_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gst_q <= G_IDLE;
      cnt_q <= '0;
    end else begin
      gst_q <= gst_d;
      if (gst_q == G_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // Datapath: seed the covariance or load operands, iterate, write back covariance
  always_ff @(posedge clk_i) begin
    if (gst_q == G_IDLE && ctl_i.start) begin
      bank_q <= ctl_i.bank;
      if (ctl_i.seed) begin
        cov_q[ctl_i.bank] <= init_i;
      end else begin
        p1_q  <= p1;
        den_q <= den;
        rem_q <= {1'b0, p1};
        // Zero measurement noise: gain pins at full scale, or zero;
        // otherwise the division shifts this start value out
        quo_q <= (r_i == '0 && p1 != '0) ? ksm_pkg::K_MAX : '0;
      end
    end
    if (gst_q == G_DIV) begin
      rem_q <= fits ? rem_sub[ksm_pkg::COV_W:0] : rem_sh[ksm_pkg::COV_W:0];
      quo_q <= {quo_q[ksm_pkg::K_W-2:0], fits};
    end
    if (gst_q == G_COV) begin
      cov_q[bank_q] <= cov_prod[ksm_pkg::COV_W+ksm_pkg::K_W-1:ksm_pkg::K_W];
    end
  end

endmodule

`default_nettype wire

FILE: sv/ksm_lane.sv
`default_nettype none

module ksm_lane (
  input  wire logic                        clk_i,
  input  wire ksm_pkg::ksm_lane_ctl_t      ctl_i,
  input  wire logic [ksm_pkg::SAMP_W-1:0]  sample_i,
  input  wire logic [ksm_pkg::K_W-1:0]     k_i,
  output logic      [ksm_pkg::SAMP_W-1:0]  filt_o
);

  localparam int unsigned EW = ksm_pkg::EST_W;
  localparam int unsigned PW = ksm_pkg::EST_W + ksm_pkg::K_W;

  logic [EW-1:0]   est_q [2];
  logic [EW-1:0]   mag_q;
  logic            neg_q;
  logic [PW-1:0]   prod_q;

  logic [EW-1:0]   x_cur;
  logic [EW+1:0]   diff;
  logic [EW+1:0]   mag_full;
  logic [PW:0]     rnd_sum;
  logic [EW-1:0]   rnd;
  logic [EW-1:0]   nx;
  logic [EW:0]     pos_sum;
  logic [16:0]     pos_r;
  logic [EW:0]     neg_mag;
  logic [EW:0]     neg_sum;
  logic [16:0]     neg_r;
  logic [16:0]     neg_val;
  logic [ksm_pkg::SAMP_W-1:0] pos_out;

  assign x_cur = est_q[ctl_i.bank];

  // Innovation s*2^16 - x and its magnitude
  assign diff = {{2{sample_i[ksm_pkg::SAMP_W-1]}}, sample_i, 16'h0000}
              - {{2{x_cur[EW-1]}}, x_cur};
  assign mag_full = diff[EW+1] ? ((EW+2)'(0) - diff) : diff;

  // Correction rounded half away from zero
  assign rnd_sum = {1'b0, prod_q} + (PW+1)'(17'h08000);
  assign rnd     = rnd_sum[EW+15:16];
  assign nx      = neg_q ? (x_cur - rnd) : (x_cur + rnd);

  // Round the estimate to 16 bits, half away from zero, saturating
  assign pos_sum = {1'b0, x_cur} + (EW+1)'(17'h08000);
  assign pos_r   = pos_sum[EW:16];
  assign pos_out = (pos_r > 17'd32767) ? 16'h7FFF : pos_r[15:0];
  assign neg_mag = (EW+1)'(0) - {x_cur[EW-1], x_cur};
  assign neg_sum = neg_mag + (EW+1)'(17'h08000);
  assign neg_r   = neg_sum[EW:16];
  assign neg_val = 17'd0 - neg_r;
  assign filt_o  = x_cur[EW-1] ? neg_val[15:0] : pos_out;

  always_ff @(posedge clk_i) begin
    if (ctl_i.seed) begin
      est_q[ctl_i.bank] <= {sample_i, 16'h0000};
    end
    if (ctl_i.diff) begin
      mag_q <= mag_full[EW-1:0];
      neg_q <= diff[EW+1];
    end
    if (ctl_i.mul) begin
      prod_q <= mag_q * k_i;
    end
    if (ctl_i.upd) begin
      est_q[ctl_i.bank] <= nx;
    end
  end

endmodule

`default_nettype wire

FILE: sv/three_axis_scalar_kalman_smoother.sv
// Channel   Direction  Handshake                      Payload
// in        input      in_valid_i / in_stall_o        func_i, sample_x_i, sample_y_i, sample_z_i
// out       output     out_valid_o / out_stall_i      filtered_x_o, filtered_y_o, filtered_z_o,
//                                                     was_seeding_o
// cfg       input      psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// A seeding word passes through the start and output states to its result register; a
// filter step also waits on the bit-serial gain divider shared by the three lanes (which
// skips its division with zero measurement noise), then the difference, multiply, update states.
// One word is worked on at a time; the next is accepted while a result waits.
// Reset clears the configuration to its defaults and both banks to unseeded.
// A stalled result holds in the output register and blocks only the final load.
`default_nettype none

module three_axis_scalar_kalman_smoother (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [15:0] sample_x_i,
  input  wire logic [15:0] sample_y_i,
  input  wire logic [15:0] sample_z_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      filtered_x_o,
  output logic [15:0]      filtered_y_o,
  output logic [15:0]      filtered_z_o,
  output logic             was_seeding_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_GAIN  = 3'd2;
  localparam logic [2:0] ST_DIFF  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic                        bank_q;
  logic [ksm_pkg::SAMP_W-1:0]  samp_q [ksm_pkg::AXES];
  logic [1:0]                  seeded_q;
  logic                        seeding_q;
  logic                        out_valid_q;
  logic [ksm_pkg::SAMP_W-1:0]  filt_q [ksm_pkg::AXES];
  logic                        was_seeding_q;

  logic [ksm_pkg::COV_W-1:0]   acc_q_q, acc_r_q, acc_p0_q;
  logic [ksm_pkg::COV_W-1:0]   gyr_q_q, gyr_r_q, gyr_p0_q;
  logic [2:0]                  reg_idx;
  logic                        cfg_wr;

  logic                        in_acc;
  logic                        out_free;
  logic                        need_seed;
  ksm_pkg::ksm_gain_ctl_t      gain_ctl;
  ksm_pkg::ksm_lane_ctl_t      lane_ctl;
  logic [ksm_pkg::K_W-1:0]     gain_k;
  logic                        gain_done;
  logic [ksm_pkg::SAMP_W-1:0]  lane_filt [ksm_pkg::AXES];
  logic [ksm_pkg::COV_W-1:0]   sel_q, sel_r, sel_p0;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      ksm_pkg::REG_ACC_Q:  prdata = {8'h00, acc_q_q};
      ksm_pkg::REG_ACC_R:  prdata = {8'h00, acc_r_q};
      ksm_pkg::REG_ACC_P0: prdata = {8'h00, acc_p0_q};
      ksm_pkg::REG_GYR_Q:  prdata = {8'h00, gyr_q_q};
      ksm_pkg::REG_GYR_R:  prdata = {8'h00, gyr_r_q};
      ksm_pkg::REG_GYR_P0: prdata = {8'h00, gyr_p0_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q_q  <= ksm_pkg::RST_ACC_Q;
      acc_r_q  <= ksm_pkg::RST_ACC_R;
      acc_p0_q <= ksm_pkg::RST_ACC_P0;
      gyr_q_q  <= ksm_pkg::RST_GYR_Q;
      gyr_r_q  <= ksm_pkg::RST_GYR_R;
      gyr_p0_q <= ksm_pkg::RST_GYR_P0;
    end else if (cfg_wr) begin
      case (reg_idx)
        ksm_pkg::REG_ACC_Q:  acc_q_q  <= pwdata[ksm_pkg::COV_W-1:0];
        ksm_pkg::REG_ACC_R:  acc_r_q  <= pwdata[ksm_pkg::COV_W-1:0];
        ksm_pkg::REG_ACC_P0: acc_p0_q <= pwdata[ksm_pkg::COV_W-1:0];
        ksm_pkg::REG_GYR_Q:  gyr_q_q  <= pwdata[ksm_pkg::COV_W-1:0];
        ksm_pkg::REG_GYR_R:  gyr_r_q  <= pwdata[ksm_pkg::COV_W-1:0];
        ksm_pkg::REG_GYR_P0: gyr_p0_q <= pwdata[ksm_pkg::COV_W-1:0];
        default: ;
      endcase
    end
  end

  // Bank register selection
  assign sel_q  = bank_q ? gyr_q_q  : acc_q_q;
  assign sel_r  = bank_q ? gyr_r_q  : acc_r_q;
  assign sel_p0 = bank_q ? gyr_p0_q : acc_p0_q;

  // Handshakes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign need_seed  = !seeded_q[bank_q];

  // Sequencer strobes
  always_comb begin
    gain_ctl.start = (state_q == ST_START);
    gain_ctl.seed  = need_seed;
    gain_ctl.bank  = bank_q;
    lane_ctl.seed  = (state_q == ST_START) && need_seed;
    lane_ctl.diff  = (state_q == ST_DIFF);
    lane_ctl.mul   = (state_q == ST_MUL);
    lane_ctl.upd   = (state_q == ST_UPD);
    lane_ctl.bank  = bank_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_START;
      ST_START: state_d = need_seed ? ST_OUT : ST_GAIN;
      ST_GAIN:  if (gain_done) state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_UPD;
      ST_UPD:   state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seeded_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_START && need_seed) begin
        seeded_q[bank_q] <= 1'b1;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the input word and remember whether it seeds
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bank_q    <= func_i;
      samp_q[0] <= sample_x_i;
      samp_q[1] <= sample_y_i;
      samp_q[2] <= sample_z_i;
    end
    if (state_q == ST_START) begin
      seeding_q <= need_seed;
    end
  end

  ksm_gain u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (gain_ctl),
    .q_i    (sel_q),
    .r_i    (sel_r),
    .init_i (sel_p0),
    .k_o    (gain_k),
    .done_o (gain_done)
  );

  for (genvar a = 0; a < ksm_pkg::AXES; a++) begin : g_lane
    ksm_lane u_lane (
      .clk_i    (clk_i),
      .ctl_i    (lane_ctl),
      .sample_i (samp_q[a]),
      .k_i      (gain_k),
      .filt_o   (lane_filt[a])
    );
  end

  // Merge the lanes into the result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      for (int a = 0; a < ksm_pkg::AXES; a++) begin
        filt_q[a] <= lane_filt[a];
      end
      was_seeding_q <= seeding_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign filtered_x_o  = filt_q[0];
  assign filtered_y_o  = filt_q[1];
  assign filtered_z_o  = filt_q[2];
  assign was_seeding_o = was_seeding_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_START)
    else $error("accepted word did not start the sequence");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result loaded outside the output step");

  a_gain_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_done |-> state_q == ST_GAIN)
    else $error("gain finished while the sequencer was not waiting");

  a_seed_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_ctl.seed |=> seeded_q[bank_q] && seeding_q)
    else $error("seeding did not mark the bank");
`endif

endmodule

`default_nettype wire

FILE: sim/three_axis_scalar_kalman_smoother_tb.sv
`default_nettype none

typedef enum logic {
  BANK_ACC  = 1'b0,
  BANK_GYRO = 1'b1
} sensor_bank_e;

typedef struct packed {
  logic [15:0] fx;
  logic [15:0] fy;
  logic [15:0] fz;
  logic        seeding;
} filtered_t;

// Mirror of both filter banks plus the queue of filtered words still owed
class smoother_checker;
  logic [ksm_pkg::COV_W-1:0] q_noise [2];
  logic [ksm_pkg::COV_W-1:0] r_noise [2];
  logic [ksm_pkg::COV_W-1:0] p_start [2];
  int               est [6];
  longint           cov [2];
  bit               seeded [2];
  filtered_t        filtered_q [$];
  int unsigned      mismatches;
  int unsigned      words_in;
  int unsigned      seeds;
  int unsigned      checked;

  function new();
    q_noise[BANK_ACC]  = ksm_pkg::RST_ACC_Q;
    r_noise[BANK_ACC]  = ksm_pkg::RST_ACC_R;
    p_start[BANK_ACC]  = ksm_pkg::RST_ACC_P0;
    q_noise[BANK_GYRO] = ksm_pkg::RST_GYR_Q;
    r_noise[BANK_GYRO] = ksm_pkg::RST_GYR_R;
    p_start[BANK_GYRO] = ksm_pkg::RST_GYR_P0;
    foreach (est[i]) est[i] = 0;
    cov[0] = 0;
    cov[1] = 0;
    seeded[0] = 1'b0;
    seeded[1] = 1'b0;
    mismatches = 0;
    words_in = 0;
    seeds = 0;
    checked = 0;
  endfunction

  function void flag(string what, int expv, int actv);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s (result %0d): expected %0d, got %0d",
               $time, what, checked, expv, actv);
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      ksm_pkg::REG_ACC_Q:  q_noise[BANK_ACC]  = value[ksm_pkg::COV_W-1:0];
      ksm_pkg::REG_ACC_R:  r_noise[BANK_ACC]  = value[ksm_pkg::COV_W-1:0];
      ksm_pkg::REG_ACC_P0: p_start[BANK_ACC]  = value[ksm_pkg::COV_W-1:0];
      ksm_pkg::REG_GYR_Q:  q_noise[BANK_GYRO] = value[ksm_pkg::COV_W-1:0];
      ksm_pkg::REG_GYR_R:  r_noise[BANK_GYRO] = value[ksm_pkg::COV_W-1:0];
      ksm_pkg::REG_GYR_P0: p_start[BANK_GYRO] = value[ksm_pkg::COV_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [ksm_pkg::COV_W-1:0] reg_value(logic [2:0] idx);
    case (idx)
      ksm_pkg::REG_ACC_Q:  return q_noise[BANK_ACC];
      ksm_pkg::REG_ACC_R:  return r_noise[BANK_ACC];
      ksm_pkg::REG_ACC_P0: return p_start[BANK_ACC];
      ksm_pkg::REG_GYR_Q:  return q_noise[BANK_GYRO];
      ksm_pkg::REG_GYR_R:  return r_noise[BANK_GYRO];
      ksm_pkg::REG_GYR_P0: return p_start[BANK_GYRO];
      default:             return '0;
    endcase
  endfunction

  // Round a Q16.16 estimate half away from zero, saturate to 16 bits
  function logic [15:0] round_est(int x);
    longint v;
    longint r;
    v = x;
    if (v >= 0) begin
      r = (v + 32768) / 65536;
      if (r > 32767) r = 32767;
    end else begin
      r = -((-v + 32768) / 65536);
      if (r < -32768) r = -32768;
    end
    return r[15:0];
  endfunction

  // Run one seed or one Kalman step for an accepted word, queue its result
  function void take_sample(sensor_bank_e bank, logic [15:0] sx, logic [15:0] sy,
                            logic [15:0] sz);
    filtered_t   res;
    longint      s [3];
    logic [15:0] rounded [3];
    longint      p1;
    longint      den;
    longint      gain;
    longint      diff;
    longint      mag;
    longint      corr;
    int          base;
    s[0] = longint'($signed(sx));
    s[1] = longint'($signed(sy));
    s[2] = longint'($signed(sz));
    base = (bank == BANK_GYRO) ? 3 : 0;
    words_in++;
    if (!seeded[bank]) begin
      // seed: raw sample becomes the estimate and passes straight out
      seeded[bank] = 1'b1;
      cov[bank] = p_start[bank];
      for (int a = 0; a < 3; a++) est[base+a] = int'(s[a] * 65536);
      res = '{sx, sy, sz, 1'b1};
      seeds++;
    end else begin
      // predict covariance, saturating, then the shared gain
      p1 = cov[bank] + longint'(q_noise[bank]);
      if (p1 > longint'(ksm_pkg::COV_MAX)) p1 = longint'(ksm_pkg::COV_MAX);
      den = p1 + longint'(r_noise[bank]);
      gain = (den == 0) ? 0 : (p1 * 65536) / den;
      if (gain > 65535) gain = 65535;
      // move each axis toward its sample, rounding the correction
      for (int a = 0; a < 3; a++) begin
        diff = s[a] * 65536 - longint'(est[base+a]);
        mag = (diff < 0) ? -diff : diff;
        corr = (mag * gain + 32768) >>> 16;
        est[base+a] = int'(longint'(est[base+a]) + ((diff < 0) ? -corr : corr));
        rounded[a] = round_est(est[base+a]);
      end
      cov[bank] = (p1 * (65536 - gain)) >>> 16;
      res = '{rounded[0], rounded[1], rounded[2], 1'b0};
    end
    filtered_q.push_back(res);
  endfunction

  // Compare one accepted result against the oldest owed word
  function void check_filtered(logic [15:0] fx, logic [15:0] fy, logic [15:0] fz,
                               logic seeding);
    filtered_t want;
    if (filtered_q.size() == 0) begin
      flag("result with no word pending", 0, 0);
      return;
    end
    want = filtered_q.pop_front();
    checked++;
    if (fx !== want.fx) flag("filtered_x", $signed(want.fx), $signed(fx));
    if (fy !== want.fy) flag("filtered_y", $signed(want.fy), $signed(fy));
    if (fz !== want.fz) flag("filtered_z", $signed(want.fz), $signed(fz));
    if (seeding !== want.seeding) flag("was_seeding", want.seeding, seeding);
  endfunction
endclass

module three_axis_scalar_kalman_smoother_tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_WORDS  = 235;
  localparam int unsigned SETTLE       = 30;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [15:0] sample_x_i = '0;
  logic [15:0] sample_y_i = '0;
  logic [15:0] sample_z_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] filtered_x_o;
  logic [15:0] filtered_y_o;
  logic [15:0] filtered_z_o;
  logic        was_seeding_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  smoother_checker sb;
  int unsigned     gap_pct = 0;
  int unsigned     stall_pct = 0;
  int unsigned     cycles = 0;
  int unsigned     cfg_writes = 0;

  three_axis_scalar_kalman_smoother dut (.*);

  always #5 clk_i = ~clk_i;

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycles,
               sb.filtered_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result side at random
  always @(posedge clk_i)
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  // Watch both handshakes
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_filtered(filtered_x_o, filtered_y_o, filtered_z_o, was_seeding_o);
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.take_sample(sensor_bank_e'(func_i), sample_x_i, sample_y_i, sample_z_i);
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic cfg_read_check(logic [2:0] idx);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== {8'h00, sb.reg_value(idx)})
      sb.flag("register readback", sb.reg_value(idx), got);
    @(posedge clk_i);
  endtask

  // Present one word, idling first at random, and hold it until taken
  task automatic send_word(sensor_bank_e bank, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= bank;
    sample_x_i <= x;
    sample_y_i <= y;
    sample_z_i <= z;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [15:0] pick_sample();
    int unsigned roll;
    roll = $urandom_range(9);
    case (roll)
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3, 4, 5: return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly workable noise values, sometimes the extremes or stray upper bits
  function automatic logic [31:0] pick_cov();
    int unsigned roll;
    roll = $urandom_range(7);
    case (roll)
      0:       return 32'h0;
      1:       return {8'h00, ksm_pkg::COV_MAX};
      2:       return 32'h1;
      3:       return $urandom;
      default: return $urandom_range(1, 1 << 18);
    endcase
  endfunction

  task automatic send_random_words(int unsigned count);
    repeat (count)
      send_word(sensor_bank_e'($urandom_range(1)), pick_sample(), pick_sample(),
                pick_sample());
    in_valid_i <= 1'b0;
  endtask

  // Wait for every owed word, then let the pipeline settle
  task automatic drain();
    while (sb.filtered_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_bank_regs(logic [31:0] aq, logic [31:0] ar, logic [31:0] ap,
                               logic [31:0] gq, logic [31:0] gr, logic [31:0] gp);
    cfg_write(ksm_pkg::REG_ACC_Q, aq);
    cfg_write(ksm_pkg::REG_ACC_R, ar);
    cfg_write(ksm_pkg::REG_ACC_P0, ap);
    cfg_write(ksm_pkg::REG_GYR_Q, gq);
    cfg_write(ksm_pkg::REG_GYR_R, gr);
    cfg_write(ksm_pkg::REG_GYR_P0, gp);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // check reset values, then load every register and two unmapped slots
    for (int i = 0; i < 6; i++) cfg_read_check(3'(i));
    set_bank_regs(pick_cov(), pick_cov(), pick_cov(), pick_cov(), pick_cov(),
                  $urandom);
    cfg_write(3'd6, $urandom);
    cfg_write(3'd7, $urandom);
    for (int i = 0; i < 6; i++) cfg_read_check(3'(i));
    set_bank_regs(ksm_pkg::RST_ACC_Q, ksm_pkg::RST_ACC_R, $urandom_range(1, 1 << 17),
                  ksm_pkg::RST_GYR_Q, ksm_pkg::RST_GYR_R, {8'hFF, ksm_pkg::COV_MAX});

    // seed both banks at the extremes, then swing between full-scale values
    send_word(BANK_ACC, 16'h7FFF, 16'h8000, 16'h0000);
    send_word(BANK_GYRO, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_word(BANK_ACC, 16'h8000, 16'h7FFF, 16'h0001);
    send_word(BANK_ACC, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_word(BANK_GYRO, 16'h7FFF, 16'h8000, 16'h0000);
    send_word(BANK_ACC, 16'h0000, 16'h0000, 16'h0000);
    send_word(BANK_GYRO, 16'h5555, 16'hAAAA, 16'h0001);
    repeat (3) send_word(BANK_GYRO, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    repeat (3) send_word(BANK_ACC, 16'h8000, 16'h8000, 16'h8000);
    in_valid_i <= 1'b0;
    drain();

    // zero measurement noise with no process noise drives the gain to its
    // limit and then the covariance to zero; max noise saturates p + q
    set_bank_regs(32'h0, 32'h0, 32'h0, {8'h00, ksm_pkg::COV_MAX},
                  {8'h00, ksm_pkg::COV_MAX}, 32'h0);
    send_word(BANK_ACC, 16'h1234, 16'hEDCC, 16'h7FFF);
    send_word(BANK_GYRO, 16'h8000, 16'h0100, 16'hFF00);
    repeat (3) send_word(BANK_ACC, 16'h8000, 16'h7FFF, 16'h0003);
    repeat (2) send_word(BANK_GYRO, 16'h7FFF, 16'h8001, 16'h0000);
    in_valid_i <= 1'b0;
    drain();
    set_bank_regs({8'h00, ksm_pkg::COV_MAX}, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0);
    send_word(BANK_ACC, 16'h4000, 16'hC000, 16'h0002);
    send_word(BANK_GYRO, 16'hFFFE, 16'h0002, 16'h8000);
    in_valid_i <= 1'b0;
    drain();

    // random phases, cycling through the idle patterns
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 68; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 68; end
        default: begin gap_pct = 7; stall_pct = 7; end
      endcase
      case (ph)
        0: set_bank_regs(ksm_pkg::RST_ACC_Q, ksm_pkg::RST_ACC_R, ksm_pkg::RST_ACC_P0,
                         ksm_pkg::RST_GYR_Q, ksm_pkg::RST_GYR_R, ksm_pkg::RST_GYR_P0);
        1: set_bank_regs({8'h00, ksm_pkg::COV_MAX}, {8'h00, ksm_pkg::COV_MAX},
                         {8'h00, ksm_pkg::COV_MAX}, {8'h00, ksm_pkg::COV_MAX},
                         {8'h00, ksm_pkg::COV_MAX}, {8'h00, ksm_pkg::COV_MAX});
        2: set_bank_regs(32'h0, 32'h1, 32'h0, 32'h0, 32'h1, 32'h0);
        default: set_bank_regs(pick_cov(), pick_cov(), pick_cov(), pick_cov(),
                               pick_cov(), pick_cov());
      endcase
      send_random_words(PHASE_WORDS);
      drain();
    end
    gap_pct = 0;
    stall_pct = 0;
    drain();

    $display("covered %0d sample words (%0d seeds) over %0d register writes",
             sb.words_in, sb.seeds, cfg_writes);
    $display("%0d filtered words checked, %0d mismatches, %0d cycles",
             sb.checked, sb.mismatches, cycles);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
